[rtl/arxp_pkg.sv]
// shared types and constants for the bounded uniform add-rotate-xor generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package arxp_pkg;

  // data widths
  localparam int WORD_W      = 32;
  localparam int LIMIT_W     = 24;
  localparam int COUNTER_W   = 25;
  localparam int CMP_W       = (COUNTER_W > LIMIT_W) ? COUNTER_W : LIMIT_W;
  localparam int BIT_CNT_W   = $clog2(WORD_W);

  // draw counter ceiling and reseed limit after reset
  localparam logic [COUNTER_W-1:0] COUNT_MAX   = {COUNTER_W{1'b1}};
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET = LIMIT_W'(1600000);

  // command codes
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_SEED    = 2'd0;
  localparam cmd_t CMD_RAW     = 2'd1;
  localparam cmd_t CMD_UNIFORM = 2'd2;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_SEEDED = 2'd1;
  localparam status_t ST_RESEED = 2'd2;

  // mix unit handshake
  typedef struct packed {
    logic load;
    logic step;
  } mix_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mix_stat_t;

  // remainder unit request and status
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[rtl/arxp_mix.sv]
// four-word add-rotate-xor state and its update step, run as phase_a then phase_b
// depends on arxp_pkg
`timescale 1ns / 1ps
`default_nettype none

module arxp_mix
  import arxp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mix_ctrl_t         ctrl,
  input  wire logic [63:0]       seed_low,
  input  wire logic [63:0]       seed_high,
  output mix_stat_t              stat,
  output logic      [WORD_W-1:0] word0
);

  logic [WORD_W-1:0] w0, w1, w2, w3;
  logic [WORD_W-1:0] w0_sum, w2_sum;
  logic              phase_a;
  logic              phase_b;
  logic              done;

  // first half of the step: the two independent sums
  assign w0_sum = w0 + w1;
  assign w2_sum = w2 + w3;

  // mix words, no reset: only read after a seed load
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      w0 <= seed_low[31:0];
      w1 <= seed_low[63:32];
      w2 <= seed_high[31:0];
      w3 <= seed_high[63:32];
    end else if (phase_a) begin
      w0 <= {w0_sum[15:0], w0_sum[31:16]};
      w1 <= {w1[18:0], w1[31:19]} ^ w0_sum;
      w2 <= w2_sum;
      w3 <= {w3[14:0], w3[31:15]} ^ w2_sum;
    end else if (phase_b) begin
      w0 <= w0 + w3;
      w2 <= w2 + w1;
    end
  end

  // phase sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_a <= 1'b0;
      phase_b <= 1'b0;
      done    <= 1'b0;
    end else begin
      phase_a <= ctrl.step;
      phase_b <= phase_a;
      done    <= phase_b;
    end
  end

  assign stat.busy = phase_a | phase_b;
  assign stat.done = done;
  assign word0     = w0;

endmodule

`default_nettype wire

[rtl/arxp_divider.sv]
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on arxp_pkg
`timescale 1ns / 1ps
`default_nettype none

module arxp_divider
  import arxp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire div_req_t          req,
  output div_stat_t              stat,
  output logic      [WORD_W-1:0] remainder
);

  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    dividend_sh;
  logic [WORD_W-1:0]    divisor;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 busy;
  logic                 done;
  logic [WORD_W:0]      partial;
  logic [WORD_W:0]      trial;

  // shift in the next dividend bit and try the subtraction
  assign partial = {rem, dividend_sh[WORD_W-1]};
  assign trial   = partial - {1'b0, divisor};

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem         <= '0;
      dividend_sh <= req.dividend;
      divisor     <= req.divisor;
    end else if (busy) begin
      dividend_sh <= {dividend_sh[WORD_W-2:0], 1'b0};
      if (trial[WORD_W]) begin
        rem <= partial[WORD_W-1:0];
      end else begin
        rem <= trial[WORD_W-1:0];
      end
    end
  end

  // bit counter and completion flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else if (busy) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BIT_CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

`default_nettype wire

[rtl/arx_prng_bounded_uniform_top.sv]
// Bounded uniform random word generator. A seed word (command 0) loads the
// four mix words in one pass and answers with status 1. A raw word (command
// 1) takes one mix step. A uniform word (command 2) with a bound of two or
// more first finds the rejection threshold on the bit-serial remainder unit,
// then draws until a draw reaches the threshold, then reduces that draw
// modulo the bound on the same unit; each rejected draw adds one more mix
// step. Status 2 is returned, with value 0, when a raw or uniform word needs
// a draw and the block is unseeded or the draw count has passed
// reseed_limit; a fresh seed clears it. One word is in flight at a time; a
// finished result sits in the output register so the next word may be
// accepted while it waits.
// depends on arxp_pkg, arxp_mix, arxp_divider
`timescale 1ns / 1ps
`default_nettype none

module arx_prng_bounded_uniform_top
  import arxp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write_en,
  input  wire logic [LIMIT_W-1:0]  cfg_write_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          command,
  input  wire logic [WORD_W-1:0]   bound,
  input  wire logic [63:0]         seed_low,
  input  wire logic [63:0]         seed_high,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [WORD_W-1:0]   value,
  output logic      [1:0]          status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_THRESH,
    S_DRAW,
    S_MIX,
    S_MOD,
    S_DONE
  } state_t;

  state_t                state;
  cmd_t                  cmd_r;
  logic [WORD_W-1:0]     bound_r;
  logic [WORD_W-1:0]     threshold;
  logic [WORD_W-1:0]     res_value;
  status_t               res_status;
  logic [LIMIT_W-1:0]    reseed_limit;
  logic [COUNTER_W-1:0]  draw_count;
  logic                  seeded;
  logic                  accept;
  logic                  draw_ok;
  logic                  keep_draw;
  logic                  out_free;
  mix_ctrl_t             mix_ctrl;
  mix_stat_t             mix_stat;
  logic [WORD_W-1:0]     word0;
  div_req_t              div_req;
  div_stat_t             div_stat;
  logic [WORD_W-1:0]     remainder;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // a draw needs a seed and a count within the limit
  assign draw_ok = seeded
                 && (CMP_W'(draw_count) <= CMP_W'(reseed_limit))
                 && (draw_count != COUNT_MAX);

  assign keep_draw = mix_stat.done && (word0 >= threshold);

  // requests to the mix and remainder units
  always_comb begin
    mix_ctrl.load    = accept && (command == CMD_SEED);
    mix_ctrl.step    = (accept && (command == CMD_RAW) && draw_ok)
                     || ((state == S_DRAW) && draw_ok);
    div_req.start    = 1'b0;
    div_req.dividend = word0;
    div_req.divisor  = bound_r;
    if (state == S_IDLE) begin
      div_req.start    = accept && (command == CMD_UNIFORM) && (bound > WORD_W'(1));
      div_req.dividend = WORD_W'(0) - bound;
      div_req.divisor  = bound;
    end else if (state == S_MIX) begin
      div_req.start    = keep_draw && (cmd_r == CMD_UNIFORM);
    end
  end

  // reseed limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      reseed_limit <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      reseed_limit <= cfg_write_data;
    end
  end

  // sequencer with seed state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seeded     <= 1'b0;
      draw_count <= '0;
      out_valid  <= 1'b0;
      value      <= '0;
      status     <= ST_OK;
      cmd_r      <= CMD_SEED;
      bound_r    <= '0;
      threshold  <= '0;
      res_value  <= '0;
      res_status <= ST_OK;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r     <= command;
            bound_r   <= bound;
            res_value <= '0;
            case (command)
              CMD_SEED: begin
                seeded     <= 1'b1;
                draw_count <= '0;
                res_status <= ST_SEEDED;
                state      <= S_DONE;
              end
              CMD_RAW: begin
                if (draw_ok) begin
                  res_status <= ST_OK;
                  state      <= S_MIX;
                end else begin
                  res_status <= ST_RESEED;
                  state      <= S_DONE;
                end
              end
              CMD_UNIFORM: begin
                res_status <= ST_OK;
                if (bound > WORD_W'(1)) begin
                  state <= S_THRESH;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_THRESH: begin
          if (div_stat.done) begin
            threshold <= remainder;
            state     <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (draw_ok) begin
            state <= S_MIX;
          end else begin
            res_status <= ST_RESEED;
            state      <= S_DONE;
          end
        end
        S_MIX: begin
          if (mix_stat.done) begin
            draw_count <= draw_count + 1'b1;
            if (cmd_r == CMD_RAW) begin
              res_value <= word0;
              state     <= S_DONE;
            end else if (keep_draw) begin
              state <= S_MOD;
            end else begin
              state <= S_DRAW;
            end
          end
        end
        S_MOD: begin
          if (div_stat.done) begin
            res_value <= remainder;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= res_value;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  arxp_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mix_ctrl),
    .seed_low  (seed_low),
    .seed_high (seed_high),
    .stat      (mix_stat),
    .word0     (word0)
  );

  arxp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .stat      (div_stat),
    .remainder (remainder)
  );

  // the mix and remainder units never run together
  assert property (@(posedge clk) disable iff (rst)
    !(mix_stat.busy && div_stat.busy))
    else $error("mix and remainder units busy together");

  // a mix step is only ever started on a seeded state
  assert property (@(posedge clk) disable iff (rst)
    mix_ctrl.step |-> seeded)
    else $error("mix step without a seed");

  // an accepted word always takes the block out of idle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word accepted while another is in flight");

  // any result other than a valid value carries zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (value == '0))
    else $error("non-zero value with a non-value status");

endmodule

`default_nettype wire

[tb/sv/arxp_result_checker.sv]
// result checker for the bounded uniform generator: predicts every result word
// from the accepted input words and compares it against the output channel
// depends on arxp_pkg
`timescale 1ns / 1ps

module arxp_result_checker
  import arxp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [LIMIT_W-1:0]  cfg_write_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  cmd_t                command,
  input  logic [WORD_W-1:0]   bound,
  input  logic [63:0]         seed_low,
  input  logic [63:0]         seed_high,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [WORD_W-1:0]   value,
  input  status_t             status,
  output int                  mismatch_count,
  output int                  pending_count
);

  typedef struct {
    logic [WORD_W-1:0] value;
    status_t           status;
  } result_word_t;

  // predicted generator state
  logic [WORD_W-1:0]    mix_q [4];
  logic                 seeded_q;
  logic [COUNTER_W-1:0] draw_cnt;
  logic [LIMIT_W-1:0]   limit_q;

  result_word_t pending_results [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic logic draw_permitted();
    return seeded_q && ({1'b0, limit_q} >= draw_cnt) && (draw_cnt < COUNT_MAX);
  endfunction

  // one add-rotate-xor step, returns the new word zero
  function automatic logic [WORD_W-1:0] mix_advance();
    logic [WORD_W-1:0] a, b, c, d;
    a = mix_q[0];
    b = mix_q[1];
    c = mix_q[2];
    d = mix_q[3];
    a = a + b;
    b = rotl(b, 13) ^ a;
    a = rotl(a, 16);
    c = c + d;
    d = rotl(d, 17) ^ c;
    a = a + d;
    c = c + b;
    mix_q[0] = a;
    mix_q[1] = b;
    mix_q[2] = c;
    mix_q[3] = d;
    draw_cnt = draw_cnt + 1'b1;
    return a;
  endfunction

  // expected result of one input word, advancing the predicted state
  function automatic result_word_t predict_result(input cmd_t cmd, input logic [WORD_W-1:0] bnd,
                                                  input logic [63:0] lo, input logic [63:0] hi);
    result_word_t      r;
    logic [WORD_W-1:0] threshold;
    logic [WORD_W-1:0] draw;
    logic              finished;
    r.value  = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_SEED: begin
        mix_q[0] = lo[31:0];
        mix_q[1] = lo[63:32];
        mix_q[2] = hi[31:0];
        mix_q[3] = hi[63:32];
        draw_cnt = '0;
        seeded_q = 1'b1;
        r.status = ST_SEEDED;
      end
      CMD_RAW: begin
        if (draw_permitted()) r.value = mix_advance();
        else r.status = ST_RESEED;
      end
      CMD_UNIFORM: begin
        if (bnd >= 2) begin
          threshold = (32'd0 - bnd) % bnd;
          finished  = 1'b0;
          // keep drawing until a draw clears the threshold or the seed runs out
          while (!finished) begin
            if (!draw_permitted()) begin
              r.status = ST_RESEED;
              finished = 1'b1;
            end else begin
              draw = mix_advance();
              if (draw >= threshold) begin
                r.value  = draw % bnd;
                finished = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    result_word_t exp_word;
    if (rst) begin
      foreach (mix_q[i]) mix_q[i] = '0;
      seeded_q = 1'b0;
      draw_cnt = '0;
      limit_q  = LIMIT_RESET;
      pending_results.delete();
    end else begin
      if (cfg_write_en) limit_q = cfg_write_data;

      // compare a delivered word with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: value %0h status %0d", value, status);
          mismatch_count++;
        end else begin
          exp_word = pending_results.pop_front();
          if (value !== exp_word.value) begin
            $error("value: expected %0h, got %0h", exp_word.value, value);
            mismatch_count++;
          end
          if (status !== exp_word.status) begin
            $error("status: expected %0d, got %0d", exp_word.status, status);
            mismatch_count++;
          end
        end
      end

      if (in_valid && in_ready)
        pending_results.push_back(predict_result(command, bound, seed_low, seed_high));
    end
    pending_count <= pending_results.size();
  end

endmodule

[tb/sv/tb_arx_prng_bounded_uniform_top.sv]
// testbench top for the bounded uniform generator: drives seed, raw and uniform
// words in bursts over several reseed limits, stalls the result side at random
// depends on arxp_pkg, arx_prng_bounded_uniform_top, arxp_result_checker
`timescale 1ns / 1ps

module tb_arx_prng_bounded_uniform_top;
  import arxp_pkg::*;

  localparam cmd_t CMD_UNUSED = 2'd3;

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                cfg_write_en   = 1'b0;
  logic [LIMIT_W-1:0]  cfg_write_data = '0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  cmd_t                command        = CMD_SEED;
  logic [WORD_W-1:0]   bound          = '0;
  logic [63:0]         seed_low       = '0;
  logic [63:0]         seed_high      = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [WORD_W-1:0]   value;
  status_t             status;
  int                  mismatch_count;
  int                  pending_count;

  int burst_left  = 0;
  int stall_phase = 0;
  int stall_mode  = 0;

  arx_prng_bounded_uniform_top DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .bound          (bound),
    .seed_low       (seed_low),
    .seed_high      (seed_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .status         (status)
  );

  arxp_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .bound          (bound),
    .seed_low       (seed_low),
    .seed_high      (seed_high),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .status         (status),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_arx_prng_bounded_uniform_top: done, errors");
    $finish;
  end

  // result side stalls in modes that are redrawn at random
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  // present one word and hold it until taken; bursts end in a random gap
  task automatic send_word(input cmd_t cmd, input logic [WORD_W-1:0] bnd,
                           input logic [63:0] lo, input logic [63:0] hi);
    in_valid  <= 1'b1;
    command   <= cmd;
    bound     <= bnd;
    seed_low  <= lo;
    seed_high <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= lim;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // bounds weighted towards the edges and towards heavy rejection
  function automatic logic [WORD_W-1:0] pick_bound();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1);
      1: return $urandom_range(2, 16);
      2: return 32'h8000_0000 + $urandom_range(1, 4096);
      3: return 32'h1 << $urandom_range(1, 31);
      4: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  // seeds are more frequent when the limit allows only a few draws
  function automatic cmd_t pick_command(input logic few_draws);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < (few_draws ? 30 : 8)) return CMD_SEED;
    if (roll < (few_draws ? 60 : 45)) return CMD_RAW;
    if (roll < 96) return CMD_UNIFORM;
    return CMD_UNUSED;
  endfunction

  initial begin
    logic [LIMIT_W-1:0] phase_limits [8];
    logic [LIMIT_W-1:0] lim;
    logic               few_draws;
    cmd_t               cmd;
    logic [63:0]        lo;
    logic [63:0]        hi;

    phase_limits = '{24'd0, 24'd1, 24'd2, 24'd7, 24'd40, 24'hFF_FFFF, 24'd3000, LIMIT_RESET};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // unseeded block, small bounds and the unused code
    send_word(CMD_RAW, '0, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'd5, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'd0, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'd1, rand64(), rand64());
    send_word(CMD_UNUSED, 32'd9, rand64(), rand64());

    // all-zero seed only feeds raw words, it draws only zero and clears only a zero threshold
    send_word(CMD_SEED, '0, 64'h0, 64'h0);
    send_word(CMD_RAW, '0, rand64(), rand64());
    send_word(CMD_RAW, '1, rand64(), rand64());

    // all-ones seed against the bound extremes
    send_word(CMD_SEED, '1, '1, '1);
    send_word(CMD_RAW, '0, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'd2, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'hFFFF_FFFF, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'h8000_0001, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'h8000_0000, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'd1, rand64(), rand64());
    send_word(CMD_UNUSED, '1, rand64(), rand64());
    send_word(CMD_SEED, '0, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'd3, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'd7, rand64(), rand64());
    settle();

    // limit of zero: one draw per seed, then exhaustion, also mid-rejection
    write_limit('0);
    send_word(CMD_RAW, '0, rand64(), rand64());
    send_word(CMD_SEED, '0, rand64(), rand64());
    send_word(CMD_RAW, '0, rand64(), rand64());
    send_word(CMD_RAW, '0, rand64(), rand64());
    send_word(CMD_SEED, '0, rand64(), rand64());
    send_word(CMD_UNIFORM, 32'h8000_0001, rand64(), rand64());
    settle();

    // random phases, one per reseed limit
    for (int p = 0; p < 8; p++) begin
      lim       = (p == 6) ? LIMIT_W'($urandom_range(100, 5000)) : phase_limits[p];
      few_draws = (lim < 50);
      write_limit(lim);
      send_word(CMD_SEED, pick_bound(), rand64(), rand64());
      for (int n = 0; n < 100; n++) begin
        cmd = pick_command(few_draws);
        lo  = rand64();
        hi  = rand64();
        if (cmd == CMD_SEED && few_draws && $urandom_range(0, 15) == 0) begin
          lo = '0;
          hi = '0;
        end else if (cmd == CMD_SEED && $urandom_range(0, 15) == 0) begin
          lo = '1;
          hi = '1;
        end
        send_word(cmd, pick_bound(), lo, hi);
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb_arx_prng_bounded_uniform_top: done, clean");
    end else begin
      $display("tb_arx_prng_bounded_uniform_top: done, errors");
    end
    $finish;
  end

endmodule
